@@ src/assert_macros.svh @@
// assertion macros used by the selector rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/ptbk_pkg.sv @@
// types and constants for the per-target best-k selector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptbk_pkg;

   localparam int SLOTS_DEFAULT   = 4;
   localparam int TARGETS_DEFAULT = 64;

   localparam int DIST_W  = 16;
   localparam int MIN_W   = 17;
   localparam int SCORE_W = 23;
   localparam int COST_W  = 52;
   localparam int ENTRY_W = 16;
   localparam int TIME_W  = 32;
   localparam int LEN_W   = 21;

   localparam logic [MIN_W-1:0]   MIN_UNREACHED = '1;
   localparam logic [6:0]         SCORE_FACTOR  = 7'd100;
   localparam logic [COST_W-1:0]  COST_MAX      = '1;

   localparam logic MODE_CLEAR   = 1'b0;
   localparam logic MODE_ELEMENT = 1'b1;

   typedef struct packed {
      logic               valid;
      logic [SCORE_W-1:0] score;
      logic [COST_W-1:0]  cost;
      logic [ENTRY_W-1:0] entry;
   } slot_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_DECIDE = 2'b10
   } state_type;

endpackage

`default_nettype wire

@@ src/per_target_best_k_selector.sv @@
// per-target best-k selector: row memory, running minimum and slot decision
// depends on ptbk_pkg and assert_macros.svh
//
// usage: one command channel (start/busy with req_ ports) carries clear items
// (req_mode 0) and distance elements (req_mode 1). a transfer happens when
// start is high and busy is low. busy stays low for clear items and for
// elements without req_last, so those go at one per cycle.
// an element with req_last reads the target's slot row from the row memory
// in its transfer cycle while the cost product is formed; the following
// cycle compares all slots of the row in parallel and writes the row back.
// busy is high during that cycle, so a last element holds off the next item
// for the read-modify-write of the row memory.
// the result is on the rsp_ ports for one cycle with rsp_strobe high, in the
// cycle after the decision; a new item may be taken in that same cycle. the
// receiver cannot stall, so every result is taken in its strobe cycle.
// reset (synchronous) empties all rows through per-row flags and clears the
// running minimum; the row memory itself needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module per_target_best_k_selector
   import ptbk_pkg::*;
#(
   parameter int SLOTS_PER_TARGET = SLOTS_DEFAULT,
   parameter int TARGETS          = TARGETS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_mode,
   input  wire logic [5:0]         req_target,
   input  wire logic [ENTRY_W-1:0] req_entry_id,
   input  wire logic               req_eligible,
   input  wire logic [TIME_W-1:0]  req_exec_time,
   input  wire logic [LEN_W-1:0]   req_length,
   input  wire logic               req_traced,
   input  wire logic [DIST_W-1:0]  req_distance,
   input  wire logic               req_last,
   output logic                    rsp_strobe,
   output logic                    rsp_scored,
   output logic                    rsp_inserted,
   output logic [1:0]              rsp_slot,
   output logic                    rsp_evicted_valid,
   output logic [ENTRY_W-1:0]      rsp_evicted_entry
);

   localparam int RW = (TARGETS > 1) ? $clog2(TARGETS) : 1;
   localparam int SW = (SLOTS_PER_TARGET > 1) ? $clog2(SLOTS_PER_TARGET) : 1;

   typedef slot_type [SLOTS_PER_TARGET-1:0] row_type;

   row_type row_mem [TARGETS];

   state_type          state_ff, state_in;
   logic [MIN_W-1:0]   min_ff, min_in;
   logic [TARGETS-1:0] row_valid_ff;
   row_type            rd_row_ff;
   logic               rowv_ff;
   logic [RW-1:0]      idx_ff;
   logic               scored_ff;
   logic               range_ff;
   logic [SCORE_W-1:0] score_ff;
   logic [COST_W-1:0]  cost_ff;
   logic [ENTRY_W-1:0] entry_ff;

   logic               rsp_strobe_ff, rsp_scored_ff, rsp_inserted_ff, rsp_ev_ff;
   logic [1:0]         rsp_slot_ff;
   logic [ENTRY_W-1:0] rsp_ev_entry_ff;

   logic               accept, acc_last, acc_clear;
   logic [31:0]        target_wide;
   logic               in_range;
   logic [RW-1:0]      req_idx;
   logic [MIN_W-1:0]   new_min;
   logic [SCORE_W-1:0] new_score;
   logic [TIME_W+LEN_W-1:0] prod;
   logic [COST_W-1:0]  new_cost;

   logic               ins, ev, wr_en;
   logic [SW-1:0]      win_idx;
   logic [ENTRY_W-1:0] ev_entry;
   row_type            wr_row;
   logic [31:0]        slot_wide;

   assign busy        = (state_ff == ST_DECIDE);
   assign accept      = start && !busy;
   assign acc_clear   = accept && (req_mode == MODE_CLEAR);
   assign acc_last    = accept && (req_mode == MODE_ELEMENT) && req_last;
   assign target_wide = 32'(req_target);
   assign in_range    = target_wide < 32'(TARGETS);
   assign req_idx     = target_wide[RW-1:0];

   // running minimum over traced elements and the score it gives
   always_comb begin
      new_min = min_ff;
      if (req_traced && (MIN_W'(req_distance) < min_ff)) begin
         new_min = MIN_W'(req_distance);
      end
      if (new_min == MIN_UNREACHED) begin
         new_score = '0;
      end else begin
         new_score = SCORE_W'(new_min[DIST_W-1:0]) * SCORE_W'(SCORE_FACTOR);
      end
      min_in = min_ff;
      if (acc_clear || acc_last) begin
         min_in = MIN_UNREACHED;
      end else if (accept) begin
         min_in = new_min;
      end
   end

   // saturating cost product
   assign prod     = req_exec_time * req_length;
   assign new_cost = prod[TIME_W+LEN_W-1] ? COST_MAX : prod[COST_W-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // slot decision over the row read from memory
   always_comb begin
      row_type            eff;
      logic               found_empty, found_worst;
      logic [SW-1:0]      empty_idx, worst_idx;
      logic [SCORE_W-1:0] maxs;
      logic [COST_W-1:0]  wc;
      eff         = rd_row_ff;
      found_empty = 1'b0;
      found_worst = 1'b0;
      empty_idx   = '0;
      worst_idx   = '0;
      maxs        = '0;
      wc          = '0;
      ins         = 1'b0;
      ev          = 1'b0;
      win_idx     = '0;
      ev_entry    = '0;
      for (int y = 0; y < SLOTS_PER_TARGET; y++) begin
         eff[y].valid = rd_row_ff[y].valid && rowv_ff;
      end
      for (int y = 0; y < SLOTS_PER_TARGET; y++) begin
         if (!eff[y].valid && !found_empty) begin
            found_empty = 1'b1;
            empty_idx   = SW'(y);
         end
         if (eff[y].score > maxs) begin
            maxs = eff[y].score;
         end
      end
      for (int y = 0; y < SLOTS_PER_TARGET; y++) begin
         if ((eff[y].score == maxs) && (eff[y].cost > wc)) begin
            wc          = eff[y].cost;
            worst_idx   = SW'(y);
            found_worst = 1'b1;
         end
      end
      if (scored_ff && range_ff) begin
         if (found_empty) begin
            ins     = 1'b1;
            win_idx = empty_idx;
         end else if (found_worst) begin
            if ((score_ff < eff[worst_idx].score) ||
                ((score_ff == eff[worst_idx].score) && (cost_ff < eff[worst_idx].cost))) begin
               ins      = 1'b1;
               ev       = 1'b1;
               win_idx  = worst_idx;
               ev_entry = eff[worst_idx].entry;
            end
         end
      end
      wr_row = eff;
      wr_row[win_idx].valid = 1'b1;
      wr_row[win_idx].score = score_ff;
      wr_row[win_idx].cost  = cost_ff;
      wr_row[win_idx].entry = entry_ff;
   end

   assign wr_en     = busy && ins;
   assign slot_wide = 32'(win_idx);

   // row memory: one read and one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[idx_ff] <= wr_row;
      end
      if (acc_last) begin
         rd_row_ff <= row_mem[req_idx];
      end
   end

   // item registers for the decision cycle
   always_ff @(posedge clock) begin
      if (acc_last) begin
         idx_ff    <= req_idx;
         rowv_ff   <= in_range ? row_valid_ff[req_idx] : 1'b0;
         scored_ff <= req_eligible && (new_score != '0);
         range_ff  <= in_range;
         score_ff  <= new_score;
         cost_ff   <= new_cost;
         entry_ff  <= req_entry_id;
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         rsp_scored_ff   <= scored_ff;
         rsp_inserted_ff <= ins;
         rsp_slot_ff     <= ins ? slot_wide[1:0] : 2'd0;
         rsp_ev_ff       <= ev;
         rsp_ev_entry_ff <= ev ? ev_entry : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         min_ff        <= MIN_UNREACHED;
         row_valid_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         min_ff        <= min_in;
         rsp_strobe_ff <= busy;
         if (acc_clear) begin
            row_valid_ff <= '0;
         end else if (wr_en) begin
            row_valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_scored        = rsp_scored_ff;
   assign rsp_inserted      = rsp_inserted_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_ev_ff;
   assign rsp_evicted_entry = rsp_ev_entry_ff;

   `ASSERT_NEXT(a_last_goes_busy, clock, reset, acc_last, busy)
   `ASSERT_SAME(a_strobe_after_decide, clock, reset, rsp_strobe, $past(busy))
   `ASSERT_SAME(a_insert_needs_score, clock, reset, rsp_strobe && rsp_inserted, rsp_scored)
   `ASSERT_SAME(a_evict_needs_insert, clock, reset, rsp_strobe && rsp_evicted_valid,
                rsp_inserted)

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// testbench for per_target_best_k_selector: directed rows, then random candidate runs
// depends on ptbk_pkg and the selector rtl; results are checked against a local predictor
`timescale 1ns / 1ps

module testbench;
   import ptbk_pkg::*;

   localparam int K            = SLOTS_DEFAULT;
   localparam int ROWS         = SLOTS_DEFAULT * TARGETS_DEFAULT;
   localparam int RANDOM_ITEMS = 1250;
   localparam int CALM_FROM    = 450;
   localparam int CALM_TO      = 750;
   localparam int LIMIT        = 2000;

   typedef struct packed {
      logic               mode;
      logic [5:0]         target;
      logic [ENTRY_W-1:0] entry_id;
      logic               eligible;
      logic [TIME_W-1:0]  exec_time;
      logic [LEN_W-1:0]   length;
      logic               traced;
      logic [DIST_W-1:0]  distance;
      logic               last;
   } elem_type;

   typedef struct packed {
      logic               scored;
      logic               inserted;
      logic [1:0]         slot;
      logic               evicted_valid;
      logic [ENTRY_W-1:0] evicted_entry;
   } outcome_type;

   typedef struct packed {
      elem_type    stim;
      logic        typed;
      outcome_type want;
   } dir_row_type;

   localparam outcome_type NOTHING = '0;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_mode = MODE_CLEAR;
   logic [5:0]         req_target = '0;
   logic [ENTRY_W-1:0] req_entry_id = '0;
   logic               req_eligible = 1'b0;
   logic [TIME_W-1:0]  req_exec_time = '0;
   logic [LEN_W-1:0]   req_length = '0;
   logic               req_traced = 1'b0;
   logic [DIST_W-1:0]  req_distance = '0;
   logic               req_last = 1'b0;
   logic               rsp_strobe;
   logic               rsp_scored;
   logic               rsp_inserted;
   logic [1:0]         rsp_slot;
   logic               rsp_evicted_valid;
   logic [ENTRY_W-1:0] rsp_evicted_entry;

   logic               slot_taken [ROWS];
   logic [SCORE_W-1:0] slot_rank  [ROWS];
   logic [COST_W-1:0]  slot_price [ROWS];
   logic [ENTRY_W-1:0] slot_owner [ROWS];
   logic [MIN_W-1:0]   least_dist;

   outcome_type outcome_q [$];
   dir_row_type directed_rows [$];
   int sent = 0;
   int results = 0;
   int insertions = 0;
   int evictions = 0;
   int errors = 0;
   int idle_cycles = 0;

   per_target_best_k_selector i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_target        (req_target),
      .req_entry_id      (req_entry_id),
      .req_eligible      (req_eligible),
      .req_exec_time     (req_exec_time),
      .req_length        (req_length),
      .req_traced        (req_traced),
      .req_distance      (req_distance),
      .req_last          (req_last),
      .rsp_strobe        (rsp_strobe),
      .rsp_scored        (rsp_scored),
      .rsp_inserted      (rsp_inserted),
      .rsp_slot          (rsp_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_entry (rsp_evicted_entry)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // running minimum, then first empty slot or worst-slot replacement
   function automatic logic update_slot_rows(input elem_type e, output outcome_type r);
      int unsigned             base;
      int                      worst;
      logic [SCORE_W-1:0]      score;
      logic [SCORE_W-1:0]      top;
      logic [COST_W-1:0]       cost;
      logic [COST_W-1:0]       worst_cost;
      logic [TIME_W+LEN_W-1:0] product;
      r = NOTHING;
      if (e.mode == MODE_CLEAR) begin
         foreach (slot_taken[i]) slot_taken[i] = 1'b0;
         least_dist = MIN_UNREACHED;
         return 1'b0;
      end
      if (e.traced && MIN_W'(e.distance) < least_dist) least_dist = MIN_W'(e.distance);
      if (!e.last) return 1'b0;
      score = (least_dist == MIN_UNREACHED) ? '0 :
              SCORE_W'(least_dist) * SCORE_W'(SCORE_FACTOR);
      least_dist = MIN_UNREACHED;
      product = (TIME_W+LEN_W)'(e.exec_time) * (TIME_W+LEN_W)'(e.length);
      cost = (product > (TIME_W+LEN_W)'(COST_MAX)) ? COST_MAX : product[COST_W-1:0];
      r.scored = e.eligible && score != '0;
      if (!r.scored) return 1'b1;
      base = e.target * K;
      worst = -1;
      for (int y = K - 1; y >= 0; y--) if (!slot_taken[base + y]) worst = y;
      if (worst < 0) begin
         top = '0;
         for (int y = 0; y < K; y++) if (slot_rank[base + y] > top) top = slot_rank[base + y];
         worst_cost = '0;
         for (int y = 0; y < K; y++) begin
            if (slot_rank[base + y] == top && slot_price[base + y] > worst_cost) begin
               worst_cost = slot_price[base + y];
               worst = y;
            end
         end
         if (worst >= 0 && !(score < slot_rank[base + worst] ||
               (score == slot_rank[base + worst] && cost < slot_price[base + worst])))
            worst = -1;
         if (worst >= 0) begin
            r.evicted_valid = 1'b1;
            r.evicted_entry = slot_owner[base + worst];
         end
      end
      if (worst >= 0) begin
         slot_taken[base + worst] = 1'b1;
         slot_rank[base + worst]  = score;
         slot_price[base + worst] = cost;
         slot_owner[base + worst] = e.entry_id;
         r.inserted = 1'b1;
         r.slot = 2'(worst);
      end
      return 1'b1;
   endfunction

   function automatic elem_type random_element(input logic last);
      elem_type    e;
      int unsigned pick;
      e.mode     = MODE_ELEMENT;
      e.target   = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(2));
      e.entry_id = ENTRY_W'($urandom());
      e.eligible = ($urandom_range(99) < 85);
      e.traced   = ($urandom_range(99) < 65);
      e.last     = last;
      pick = $urandom_range(9);
      if (pick < 6) e.distance = DIST_W'($urandom_range(4));
      else if (pick < 9) e.distance = DIST_W'($urandom());
      else e.distance = '1;
      pick = $urandom_range(7);
      if (pick == 0) e.exec_time = '0;
      else if (pick == 1) e.exec_time = '1;
      else if (pick < 5) e.exec_time = TIME_W'($urandom_range(7));
      else e.exec_time = $urandom();
      pick = $urandom_range(7);
      if (pick < 4) e.length = LEN_W'($urandom_range(7));
      else if (pick < 6) e.length = LEN_W'($urandom_range(1048576));
      else if (pick == 6) e.length = LEN_W'($urandom_range(2097151));
      else e.length = LEN_W'(1048576);
      return e;
   endfunction

   function automatic void add_row(input elem_type s, input logic typed, input outcome_type want);
      directed_rows.insert(directed_rows.size(), dir_row_type'{s, typed, want});
   endfunction

   task automatic transfer_item(input elem_type s, input logic typed, input outcome_type want);
      outcome_type predicted;
      int unsigned gap;
      if ((sent < CALM_FROM || sent >= CALM_TO) && $urandom_range(99) < 35) begin
         gap = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_mode      <= s.mode;
      req_target    <= s.target;
      req_entry_id  <= s.entry_id;
      req_eligible  <= s.eligible;
      req_exec_time <= s.exec_time;
      req_length    <= s.length;
      req_traced    <= s.traced;
      req_distance  <= s.distance;
      req_last      <= s.last;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
      if (update_slot_rows(s, predicted)) begin
         outcome_q.insert(outcome_q.size(), typed ? want : predicted);
      end
   endtask

   task automatic await_idle();
      start <= 1'b0;
      @(posedge clock);
      while (outcome_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report(input string what, input outcome_type want, input outcome_type got);
      errors++;
      if (errors <= 10)
         $display("%s: want %0b %0b %0d %0b/%h, got %0b %0b %0d %0b/%h",
                  what, want.scored, want.inserted, want.slot, want.evicted_valid,
                  want.evicted_entry, got.scored, got.inserted, got.slot, got.evicted_valid,
                  got.evicted_entry);
   endtask

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_strobe) begin
         got = {rsp_scored, rsp_inserted, rsp_slot, rsp_evicted_valid, rsp_evicted_entry};
         results++;
         if (outcome_q.size() == 0) begin
            report("unexpected result", NOTHING, got);
         end else begin
            want = outcome_q.pop_front();
            if (got !== want) report("mismatch", want, got);
            insertions += got.inserted;
            evictions += got.evicted_valid;
         end
      end
   end

   initial begin
      elem_type s;
      int       run_len;
      int       next_drain;
      foreach (slot_taken[i]) begin
         slot_taken[i] = 1'b0;
         slot_rank[i]  = '1;
         slot_price[i] = '0;
         slot_owner[i] = '0;
      end
      least_dist = MIN_UNREACHED;

      // first slot, unreached, zero distance, ineligible
      add_row(elem_type'{MODE_ELEMENT, 6'd0, 16'h0001, 1'b1, 32'd1, 21'd1, 1'b1, 16'd1, 1'b1},
              1'b1, outcome_type'{1'b1, 1'b1, 2'd0, 1'b0, 16'h0});
      add_row(elem_type'{MODE_ELEMENT, 6'd0, 16'h0002, 1'b1, 32'd1, 21'd1, 1'b0, 16'd5, 1'b1},
              1'b1, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd0, 16'h0002, 1'b1, 32'd1, 21'd1, 1'b1, 16'd0, 1'b1},
              1'b1, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd0, 16'h0002, 1'b0, 32'd1, 21'd1, 1'b1, 16'd3, 1'b1},
              1'b1, NOTHING);
      // multi-element run, largest distance, fields from the last element
      add_row(elem_type'{MODE_ELEMENT, 6'd9, 16'h1234, 1'b0, 32'd7, 21'd7, 1'b1, 16'hFFFF, 1'b0},
              1'b0, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd9, 16'h1234, 1'b0, 32'd7, 21'd7, 1'b0, 16'd2, 1'b0},
              1'b0, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd0, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 21'h100000, 1'b1,
                         16'hFFFF, 1'b1}, 1'b1, outcome_type'{1'b1, 1'b1, 2'd1, 1'b0, 16'h0});
      add_row(elem_type'{MODE_ELEMENT, 6'd0, 16'h0002, 1'b1, 32'd2, 21'd3, 1'b1, 16'd2, 1'b1},
              1'b1, outcome_type'{1'b1, 1'b1, 2'd2, 1'b0, 16'h0});
      add_row(elem_type'{MODE_ELEMENT, 6'd0, 16'h0003, 1'b1, 32'd3, 21'd3, 1'b1, 16'd2, 1'b1},
              1'b1, outcome_type'{1'b1, 1'b1, 2'd3, 1'b0, 16'h0});
      // full row: evict highest score, then equal-score cost ties
      add_row(elem_type'{MODE_ELEMENT, 6'd0, 16'h0004, 1'b1, 32'd1, 21'd1, 1'b1, 16'd2, 1'b1},
              1'b1, outcome_type'{1'b1, 1'b1, 2'd1, 1'b1, 16'hFFFF});
      add_row(elem_type'{MODE_ELEMENT, 6'd0, 16'h0005, 1'b1, 32'd9, 21'd1, 1'b1, 16'd2, 1'b1},
              1'b0, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd0, 16'h0006, 1'b1, 32'd2, 21'd4, 1'b1, 16'd2, 1'b1},
              1'b0, NOTHING);
      // saturated cost on the top target
      add_row(elem_type'{MODE_ELEMENT, 6'd63, 16'h0010, 1'b1, 32'hFFFFFFFF, 21'h1FFFFF, 1'b1,
                         16'd2, 1'b1}, 1'b0, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd63, 16'h0011, 1'b1, 32'd1, 21'd1, 1'b1, 16'd2, 1'b1},
              1'b0, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd63, 16'h0012, 1'b1, 32'hFFFFFFFF, 21'h1FFFFF, 1'b1,
                         16'd2, 1'b1}, 1'b0, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd63, 16'h0013, 1'b1, 32'd1, 21'd2, 1'b1, 16'd2, 1'b1},
              1'b0, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd63, 16'h0014, 1'b1, 32'hFFFFFFFF, 21'h100001, 1'b1,
                         16'd2, 1'b1}, 1'b0, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd63, 16'h0015, 1'b1, 32'hFFFFFFFF, 21'h100000, 1'b1,
                         16'd2, 1'b1}, 1'b0, NOTHING);
      // all costs zero: nothing can be replaced
      add_row(elem_type'{MODE_ELEMENT, 6'd5, 16'h0020, 1'b1, 32'd0, 21'd1, 1'b1, 16'd3, 1'b1},
              1'b0, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd5, 16'h0021, 1'b1, 32'd0, 21'd9, 1'b1, 16'd3, 1'b1},
              1'b0, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd5, 16'h0022, 1'b1, 32'd0, 21'd0, 1'b1, 16'd3, 1'b1},
              1'b0, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd5, 16'h0023, 1'b1, 32'd0, 21'h1FFFFF, 1'b1, 16'd3,
                         1'b1}, 1'b0, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd5, 16'h0024, 1'b1, 32'd5, 21'd5, 1'b1, 16'd1, 1'b1},
              1'b1, outcome_type'{1'b1, 1'b0, 2'd0, 1'b0, 16'h0});
      // clear in the middle of a run, then rows are empty
      add_row(elem_type'{MODE_ELEMENT, 6'd5, 16'h0025, 1'b1, 32'd1, 21'd1, 1'b1, 16'd1, 1'b0},
              1'b0, NOTHING);
      add_row(elem_type'{MODE_CLEAR, 6'd42, 16'hA5A5, 1'b1, 32'hDEADBEEF, 21'h0ABCDE, 1'b1,
                         16'h5A5A, 1'b1}, 1'b0, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd5, 16'h0026, 1'b1, 32'd1, 21'd1, 1'b0, 16'd9, 1'b1},
              1'b1, NOTHING);
      add_row(elem_type'{MODE_ELEMENT, 6'd0, 16'h0030, 1'b1, 32'd1, 21'd1, 1'b1, 16'd7, 1'b1},
              1'b1, outcome_type'{1'b1, 1'b1, 2'd0, 1'b0, 16'h0});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k])
         transfer_item(directed_rows[k].stim, directed_rows[k].typed, directed_rows[k].want);
      await_idle();

      next_drain = sent + 300;
      while (sent < directed_rows.size() + RANDOM_ITEMS) begin
         if ($urandom_range(29) == 0) begin
            s = random_element(1'($urandom_range(1)));
            s.mode = MODE_CLEAR;
            transfer_item(s, 1'b0, NOTHING);
         end
         run_len = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
         for (int k = 0; k < run_len; k++) begin
            s = random_element(k == run_len - 1);
            // broken run
            if (k != run_len - 1 && $urandom_range(49) == 0) s.mode = MODE_CLEAR;
            transfer_item(s, 1'b0, NOTHING);
         end
         if (sent >= next_drain) begin
            await_idle();
            next_drain = sent + 300;
         end
      end

      await_idle();
      repeat (4) @(posedge clock);
      $display("run covered %0d transfers and %0d checked results", sent, results);
      $display("candidates placed %0d times, %0d of them displacing an occupant",
               insertions, evictions);
      if (errors == 0 && outcome_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
